[sv/nctm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest color table match package
// Shared sizes, codes and types of the nearest color table match block.
// ----------------------------------------------------------------------------
package nctm_pkg;

   localparam int MAX_ENTRIES = 64;
   localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

   localparam int COUNT_W     = 7;
   localparam int CH_W        = 8;
   localparam int COORD_W     = 16;
   localparam int COLOR_W     = 3 * CH_W;
   localparam int COORDS_W    = 4 * COORD_W;
   localparam int DIST_W      = 2 * CH_W + 2;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // Register index, decoded from the word address bit.
   localparam logic REG_ENTRY_COUNT = 1'b0;

   typedef enum logic {
      REQ_LOAD  = 1'b0,
      REQ_QUERY = 1'b1
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FETCH,
      ST_FETCH_WAIT
   } state_type;

   typedef struct packed {
      logic [CH_W-1:0] r;
      logic [CH_W-1:0] g;
      logic [CH_W-1:0] b;
   } color_type;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] idx;
   } tag_type;

   typedef struct packed {
      logic              valid;
      logic [IDX_W-1:0]  idx;
      logic [DIST_W-1:0] sq_dist;
   } dist_type;

   typedef struct packed {
      logic             busy;
      logic             color_rd_en;
      logic [IDX_W-1:0] color_rd_addr;
      logic             coord_rd_en;
      logic [IDX_W-1:0] best_idx;
      logic             rsp_load;
      logic             found;
   } seq_ctrl_type;

endpackage

[sv/nearest_color_table_match.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest color table match
// Table of colored entries searched for the nearest color to a query.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                       Payload
//  request   start / busy                    req_type, entry index, color, coords
//  response  rsp_valid, one-cycle strobe     match valid mark and coordinates
//  config    psel/penable/pwrite, pready=1   entry_count at byte address 0
//
// A load request is written into the table at the accepting edge and leaves
// busy low, so another request may follow in the next cycle. A query request
// holds busy high until its response is loaded. The scan covers entry_count
// entries (saturated to the table depth), none with an empty table, and
// feeds one table entry per cycle from the color RAM through the
// shared distance unit, then the winner's coordinates are fetched from the
// coordinate RAM. Reset is synchronous and clears the control state, the
// entry count and the entry valid marks; the table RAMs are not cleared.
// The response receiver cannot stall; each response is shown for one cycle.
//
module nearest_color_table_match (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_type,
   input  logic [5:0]                         req_entry_index,
   input  logic [nctm_pkg::CH_W-1:0]          req_color_r,
   input  logic [nctm_pkg::CH_W-1:0]          req_color_g,
   input  logic [nctm_pkg::CH_W-1:0]          req_color_b,
   input  logic [nctm_pkg::COORD_W-1:0]       req_ref_u0,
   input  logic [nctm_pkg::COORD_W-1:0]       req_ref_v0,
   input  logic [nctm_pkg::COORD_W-1:0]       req_ref_u1,
   input  logic [nctm_pkg::COORD_W-1:0]       req_ref_v1,
   input  logic                               req_ref_valid,
   // Response channel
   output logic                               rsp_valid,
   output logic                               rsp_match_valid,
   output logic [nctm_pkg::COORD_W-1:0]       rsp_match_u0,
   output logic [nctm_pkg::COORD_W-1:0]       rsp_match_v0,
   output logic [nctm_pkg::COORD_W-1:0]       rsp_match_u1,
   output logic [nctm_pkg::COORD_W-1:0]       rsp_match_v1,
   // Configuration port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [nctm_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [nctm_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [nctm_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready
);
   import nctm_pkg::*;

   seq_ctrl_type          ctrl;
   tag_type               tag;
   dist_type              dist_res;
   color_type             query_ff, query_in;
   color_type             entry_color;
   logic [COLOR_W-1:0]    color_rd_data;
   logic [COORDS_W-1:0]   coord_rd_data;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]      limit;
   logic [MAX_ENTRIES-1:0] valid_bits_ff, valid_bits_in;
   logic                  accept;
   logic                  start_query;
   logic                  load_ok;
   logic [IDX_W-1:0]      wr_addr;
   logic                  csr_write;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_match_valid_ff, rsp_match_valid_in;
   logic [COORDS_W-1:0]   rsp_coords_ff, rsp_coords_in;

   // A request is taken whenever the scan engine is idle.
   assign busy        = ctrl.busy;
   assign accept      = start && !ctrl.busy;
   assign start_query = accept && (req_type == REQ_QUERY);

   // Loads outside the table depth are dropped.
   assign load_ok = accept && (req_type == REQ_LOAD) &&
                    (int'(req_entry_index) < MAX_ENTRIES);
   assign wr_addr = IDX_W'(req_entry_index);

   // The register is decoded on the word address bit; byte lanes are ignored.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready &&
                      (paddr[2] == REG_ENTRY_COUNT);
   assign prdata    = (paddr[2] == REG_ENTRY_COUNT) ? CSR_DATA_W'(count_ff) : '0;

   // A count above the table depth scans the whole table.
   assign limit = (int'(count_ff) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES)
                                                 : CNT_W'(count_ff);

   always_comb begin
      count_in      = count_ff;
      query_in      = query_ff;
      valid_bits_in = valid_bits_ff;
      if (csr_write) begin
         count_in = pwdata[COUNT_W-1:0];
      end
      if (start_query) begin
         query_in.r = req_color_r;
         query_in.g = req_color_g;
         query_in.b = req_color_b;
      end
      if (load_ok) begin
         valid_bits_in[wr_addr] = req_ref_valid;
      end
   end

   // The response register is loaded once the winner's coordinates are read.
   // With an empty table the response is invalid with zero coordinates.
   always_comb begin
      rsp_valid_in       = ctrl.rsp_load;
      rsp_match_valid_in = rsp_match_valid_ff;
      rsp_coords_in      = rsp_coords_ff;
      if (ctrl.rsp_load) begin
         if (ctrl.found) begin
            rsp_match_valid_in = valid_bits_ff[ctrl.best_idx];
            rsp_coords_in      = coord_rd_data;
         end else begin
            rsp_match_valid_in = 1'b0;
            rsp_coords_in      = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         valid_bits_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         valid_bits_ff <= valid_bits_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      query_ff           <= query_in;
      rsp_match_valid_ff <= rsp_match_valid_in;
      rsp_coords_ff      <= rsp_coords_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_match_valid = rsp_match_valid_ff;
   assign rsp_match_u0    = rsp_coords_ff[COORD_W-1:0];
   assign rsp_match_v0    = rsp_coords_ff[2*COORD_W-1:COORD_W];
   assign rsp_match_u1    = rsp_coords_ff[3*COORD_W-1:2*COORD_W];
   assign rsp_match_v1    = rsp_coords_ff[4*COORD_W-1:3*COORD_W];

   // Entry colors, packed red high.
   nctm_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (MAX_ENTRIES)
   ) u_color_ram (
      .clock   (clock),
      .wr_en   (load_ok),
      .wr_addr (wr_addr),
      .wr_data ({req_color_r, req_color_g, req_color_b}),
      .rd_en   (ctrl.color_rd_en),
      .rd_addr (ctrl.color_rd_addr),
      .rd_data (color_rd_data)
   );

   // Entry coordinates, packed with u0 in the low half-word.
   nctm_ram #(
      .WIDTH (COORDS_W),
      .DEPTH (MAX_ENTRIES)
   ) u_coord_ram (
      .clock   (clock),
      .wr_en   (load_ok),
      .wr_addr (wr_addr),
      .wr_data ({req_ref_v1, req_ref_u1, req_ref_v0, req_ref_u0}),
      .rd_en   (ctrl.coord_rd_en),
      .rd_addr (ctrl.best_idx),
      .rd_data (coord_rd_data)
   );

   assign entry_color = color_type'(color_rd_data);

   nctm_dist u_dist (
      .clock  (clock),
      .reset  (reset),
      .query  (query_ff),
      .entry  (entry_color),
      .tag    (tag),
      .result (dist_res)
   );

   nctm_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .start_query (start_query),
      .limit       (limit),
      .result      (dist_res),
      .tag         (tag),
      .ctrl        (ctrl)
   );

`ifndef SYNTHESIS
   // A response is only produced once the scan engine has gone idle.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !busy)
      else $error("response shown while the scan engine is busy");

   // Each query gives a single one-cycle response.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("response strobe held for more than one cycle");

   // A load never occupies the scan engine.
   assert property (@(posedge clock) disable iff (reset)
      (accept && (req_type == REQ_LOAD)) |=> !busy)
      else $error("load request made the block busy");

   // A query always starts a scan.
   assert property (@(posedge clock) disable iff (reset) start_query |=> busy)
      else $error("query request did not start a scan");
`endif

endmodule

[sv/nctm_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module nctm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/nctm_dist.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Squared distance unit
// Registered squared Euclidean distance between the query and one entry color.
// ----------------------------------------------------------------------------
module nctm_dist (
   input  logic                 clock,
   input  logic                 reset,
   input  nctm_pkg::color_type  query,
   input  nctm_pkg::color_type  entry,
   input  nctm_pkg::tag_type    tag,
   output nctm_pkg::dist_type   result
);
   import nctm_pkg::*;

   logic [CH_W-1:0]   diff_r, diff_g, diff_b;
   logic [2*CH_W-1:0] sq_r, sq_g, sq_b;
   dist_type          result_ff, result_in;

   always_comb begin
      diff_r = (query.r >= entry.r) ? query.r - entry.r : entry.r - query.r;
      diff_g = (query.g >= entry.g) ? query.g - entry.g : entry.g - query.g;
      diff_b = (query.b >= entry.b) ? query.b - entry.b : entry.b - query.b;
      sq_r   = diff_r * diff_r;
      sq_g   = diff_g * diff_g;
      sq_b   = diff_b * diff_b;
      result_in.valid   = tag.valid;
      result_in.idx     = tag.idx;
      result_in.sq_dist = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         result_ff.valid <= 1'b0;
      end else begin
         result_ff.valid <= result_in.valid;
      end
      result_ff.idx     <= result_in.idx;
      result_ff.sq_dist <= result_in.sq_dist;
   end

   assign result = result_ff;

endmodule

[sv/nctm_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scan sequencer
// Walks the table entries through the distance unit and keeps the best one.
// ----------------------------------------------------------------------------
module nctm_seq (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start_query,
   input  logic [nctm_pkg::CNT_W-1:0]     limit,
   input  nctm_pkg::dist_type             result,
   output nctm_pkg::tag_type              tag,
   output nctm_pkg::seq_ctrl_type         ctrl
);
   import nctm_pkg::*;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  limit_ff, limit_in;
   tag_type           tag_ff, tag_in;
   logic [DIST_W-1:0] best_ff, best_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   logic              found_ff, found_in;
   logic              issue;
   logic              update;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start_query) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cnt_ff >= limit_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!tag_ff.valid && !result.valid) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH:      state_in = ST_FETCH_WAIT;
         ST_FETCH_WAIT: state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      issue              = (state_ff == ST_SCAN) && (cnt_ff < limit_ff);
      ctrl.busy          = (state_ff != ST_IDLE);
      ctrl.color_rd_en   = issue;
      ctrl.color_rd_addr = cnt_ff[IDX_W-1:0];
      ctrl.coord_rd_en   = (state_ff == ST_FETCH);
      ctrl.best_idx      = best_idx_ff;
      ctrl.rsp_load      = (state_ff == ST_FETCH_WAIT);
      ctrl.found         = found_ff;
   end

   // Scan counter and running minimum. Ties keep the earlier entry.
   always_comb begin
      cnt_in      = cnt_ff;
      limit_in    = limit_ff;
      found_in    = found_ff;
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      update      = result.valid && (!found_ff || (result.sq_dist < best_ff));
      tag_in.valid = issue;
      tag_in.idx   = cnt_ff[IDX_W-1:0];
      if ((state_ff == ST_IDLE) && start_query) begin
         cnt_in   = '0;
         limit_in = limit;
         found_in = 1'b0;
      end else if (issue) begin
         cnt_in = CNT_W'(cnt_ff + 1'b1);
      end
      if (update) begin
         best_in     = result.sq_dist;
         best_idx_in = result.idx;
         found_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tag_ff.valid <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tag_ff.valid <= tag_in.valid;
         found_ff     <= found_in;
      end
      tag_ff.idx  <= tag_in.idx;
      cnt_ff      <= cnt_in;
      limit_ff    <= limit_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
   end

   assign tag = tag_ff;

endmodule

[bench/nearest_color_table_match_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest color table match testbench
// Loads table entries and issues nearest color queries against the block,
// checking every response against one typed into the directed script or one
// from a behavioral predictor that shadows the table and the entry count,
// under bursty request timing and several entry count settings, including empty, full and saturated tables.
// ----------------------------------------------------------------------------
module nearest_color_table_match_test;

   import nctm_pkg::*;

   localparam int PERIOD_NS   = 10;
   localparam int RESET_CYCLES = 8;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int TABLE_DEPTH = 64;
   localparam int PHASES      = 24;
   localparam int PHASE_ITEMS = 65;
   // Idle time after the final drain, before the run ends.
   localparam int TAIL_CYCLES = 80;

   localparam logic [CSR_ADDR_W-1:0] ENTRY_COUNT_ADDR = {REG_ENTRY_COUNT, 2'b00};

   // Expected response of one query. Coordinates are kept as {u0, v0, u1, v1}.
   typedef struct packed {
      logic        valid;
      logic [63:0] coords;
   } match_type;

   // One step of the directed script. When set_count is high the entry count
   // is rewritten (with the block idle) before the request goes out. When
   // fixed is high the response is the one typed into the row; otherwise the
   // predictor supplies it.
   typedef struct packed {
      bit           set_count;
      logic [6:0]   count;
      req_kind_type kind;
      logic [5:0]   index;
      logic [23:0]  rgb;
      logic [63:0]  coords;
      logic         placed;
      bit           fixed;
      logic         exp_valid;
      logic [63:0]  exp_coords;
   } script_row_type;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic                    req_type;
   logic [5:0]              req_entry_index;
   logic [CH_W-1:0]         req_color_r;
   logic [CH_W-1:0]         req_color_g;
   logic [CH_W-1:0]         req_color_b;
   logic [COORD_W-1:0]      req_ref_u0;
   logic [COORD_W-1:0]      req_ref_v0;
   logic [COORD_W-1:0]      req_ref_u1;
   logic [COORD_W-1:0]      req_ref_v1;
   logic                    req_ref_valid;
   logic                    rsp_valid;
   logic                    rsp_match_valid;
   logic [COORD_W-1:0]      rsp_match_u0;
   logic [COORD_W-1:0]      rsp_match_v0;
   logic [COORD_W-1:0]      rsp_match_u1;
   logic [COORD_W-1:0]      rsp_match_v1;
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic [CSR_ADDR_W-1:0]   paddr;
   logic [CSR_DATA_W-1:0]   pwdata;
   logic [CSR_DATA_W-1:0]   prdata;
   logic                    pready;

   nearest_color_table_match dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_entry_index (req_entry_index),
      .req_color_r     (req_color_r),
      .req_color_g     (req_color_g),
      .req_color_b     (req_color_b),
      .req_ref_u0      (req_ref_u0),
      .req_ref_v0      (req_ref_v0),
      .req_ref_u1      (req_ref_u1),
      .req_ref_v1      (req_ref_v1),
      .req_ref_valid   (req_ref_valid),
      .rsp_valid       (rsp_valid),
      .rsp_match_valid (rsp_match_valid),
      .rsp_match_u0    (rsp_match_u0),
      .rsp_match_v0    (rsp_match_v0),
      .rsp_match_u1    (rsp_match_u1),
      .rsp_match_v1    (rsp_match_v1),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always #(PERIOD_NS / 2) clock = ~clock;

   // Shadow copy of the table and of the entry count register.
   logic [23:0] palette_rgb    [TABLE_DEPTH];
   logic [63:0] palette_coords [TABLE_DEPTH];
   logic        palette_placed [TABLE_DEPTH];
   int          active_entries;

   // Responses still owed by the block, oldest first.
   match_type pending_matches[$];
   match_type oldest_match;

   int  errors;
   int  cycle_count;
   int  loads_sent;
   int  queries_sent;
   int  responses_seen;
   int  count_settings;
   int  burst_left;
   bit  steady;

   // Channel values that tend to produce ties and boundary distances.
   logic [7:0] channel_extremes [6] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE};

   // Directed script: empty table first, then a handful of entries with
   // opposite corners of the color cube, an exact tie between entries 0 and
   // 2, the highest entry index, and finally an empty table again.
   script_row_type directed_script [19] = '{
      '{1'b0, 7'd0, REQ_QUERY, 6'd0,  24'h000000, 64'h0000_0000_0000_0000, 1'b0,
        1'b1, 1'b0, 64'h0000_0000_0000_0000},
      '{1'b0, 7'd0, REQ_QUERY, 6'd63, 24'hFFFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
        1'b1, 1'b0, 64'h0000_0000_0000_0000},
      '{1'b0, 7'd0, REQ_LOAD,  6'd0,  24'h000000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
        1'b0, 1'b0, 64'h0},
      '{1'b0, 7'd0, REQ_LOAD,  6'd1,  24'hFFFFFF, 64'h0001_8000_7FFF_00FF, 1'b0,
        1'b0, 1'b0, 64'h0},
      '{1'b0, 7'd0, REQ_LOAD,  6'd2,  24'h000000, 64'hAAAA_5555_AAAA_5555, 1'b0,
        1'b0, 1'b0, 64'h0},
      '{1'b0, 7'd0, REQ_LOAD,  6'd3,  24'hFF0000, 64'h1111_2222_3333_4444, 1'b1,
        1'b0, 1'b0, 64'h0},
      '{1'b0, 7'd0, REQ_LOAD,  6'd63, 24'h00FF00, 64'hFFFF_0000_FFFF_0000, 1'b1,
        1'b0, 1'b0, 64'h0},
      '{1'b1, 7'd1, REQ_QUERY, 6'd0,  24'hFFFFFF, 64'h0, 1'b0,
        1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
      '{1'b0, 7'd0, REQ_QUERY, 6'd0,  24'h000000, 64'h0, 1'b0,
        1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
      '{1'b1, 7'd4, REQ_QUERY, 6'd0,  24'h000000, 64'h0, 1'b0,
        1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
      '{1'b0, 7'd0, REQ_QUERY, 6'd0,  24'hFFFFFF, 64'h0, 1'b0,
        1'b1, 1'b0, 64'h0001_8000_7FFF_00FF},
      '{1'b0, 7'd0, REQ_QUERY, 6'd0,  24'hFF0000, 64'h0, 1'b0,
        1'b1, 1'b1, 64'h1111_2222_3333_4444},
      '{1'b0, 7'd0, REQ_QUERY, 6'd0,  24'hC80A0A, 64'h0, 1'b0, 1'b0, 1'b0, 64'h0},
      '{1'b0, 7'd0, REQ_QUERY, 6'd0,  24'h808080, 64'h0, 1'b0, 1'b0, 1'b0, 64'h0},
      '{1'b0, 7'd0, REQ_QUERY, 6'd63, 24'h00FF00, 64'h5A5A_A5A5_0F0F_F0F0, 1'b1,
        1'b0, 1'b0, 64'h0},
      '{1'b0, 7'd0, REQ_LOAD,  6'd2,  24'h0A0A0A, 64'h0F0F_F0F0_0F0F_F0F0, 1'b1,
        1'b0, 1'b0, 64'h0},
      '{1'b0, 7'd0, REQ_QUERY, 6'd0,  24'h050505, 64'h0, 1'b0, 1'b0, 1'b0, 64'h0},
      '{1'b0, 7'd0, REQ_QUERY, 6'd0,  24'h060606, 64'h0, 1'b0, 1'b0, 1'b0, 64'h0},
      '{1'b1, 7'd0, REQ_QUERY, 6'd5,  24'h123456, 64'h0, 1'b0,
        1'b1, 1'b0, 64'h0000_0000_0000_0000}
   };

   // Nearest entry search over the shadow table. The count saturates at the
   // table depth, the search starts from the largest signed 32-bit distance,
   // and only a strictly smaller distance replaces the current best, so ties
   // stay with the lower index. An empty table yields an all-zero response.
   function automatic match_type nearest_entry(input logic [23:0] rgb);
      match_type best;
      int        best_dist;
      int        sq_sum;
      int        span;
      int        dr;
      int        dg;
      int        db;
      best      = '0;
      best_dist = 32'h7fff_ffff;
      span      = (active_entries > TABLE_DEPTH) ? TABLE_DEPTH : active_entries;
      for (int i = 0; i < span; i++) begin
         dr     = int'(rgb[23:16]) - int'(palette_rgb[i][23:16]);
         dg     = int'(rgb[15:8])  - int'(palette_rgb[i][15:8]);
         db     = int'(rgb[7:0])   - int'(palette_rgb[i][7:0]);
         sq_sum = dr * dr + dg * dg + db * db;
         if (sq_sum < best_dist) begin
            best_dist   = sq_sum;
            best.valid  = palette_placed[i];
            best.coords = palette_coords[i];
         end
      end
      return best;
   endfunction

   function automatic logic [7:0] random_channel();
      if ($urandom_range(0, 2) == 0) begin
         return channel_extremes[$urandom_range(0, 5)];
      end
      return 8'($urandom());
   endfunction

   // Colors are drawn from three pools: a copy of a stored entry (distance
   // zero, and ties when entries share colors), channels near the extremes,
   // and plain random colors.
   function automatic logic [23:0] random_color();
      case ($urandom_range(0, 3))
         0: begin
            return palette_rgb[$urandom_range(0, TABLE_DEPTH - 1)];
         end
         1: begin
            return {random_channel(), random_channel(), random_channel()};
         end
         default: begin
            return 24'($urandom());
         end
      endcase
   endfunction

   function automatic logic [15:0] random_coord();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic logic [63:0] random_coords();
      return {random_coord(), random_coord(), random_coord(), random_coord()};
   endfunction

   // Drives one request and holds it until the block takes it. Called on a
   // rising edge; returns on the edge at which the request was accepted.
   // The shadow table is updated, or the expected response queued, right at
   // that edge.
   task automatic issue(input req_kind_type kind, input logic [5:0] index,
                        input logic [23:0] rgb, input logic [63:0] coords,
                        input logic placed, input bit fixed,
                        input match_type fixed_match);
      start           <= 1'b1;
      req_type        <= kind;
      req_entry_index <= index;
      req_color_r     <= rgb[23:16];
      req_color_g     <= rgb[15:8];
      req_color_b     <= rgb[7:0];
      req_ref_u0      <= coords[63:48];
      req_ref_v0      <= coords[47:32];
      req_ref_u1      <= coords[31:16];
      req_ref_v1      <= coords[15:0];
      req_ref_valid   <= placed;
      do @(posedge clock); while (busy);
      if (kind == REQ_LOAD) begin
         palette_rgb[index]    = rgb;
         palette_coords[index] = coords;
         palette_placed[index] = placed;
         loads_sent++;
      end else begin
         pending_matches.insert(pending_matches.size(),
                                fixed ? fixed_match : nearest_entry(rgb));
         queries_sent++;
      end
   endtask

   // Sender pacing: bursts of random length separated by random gaps, unless
   // the current phase runs back to back.
   task automatic pace();
      if (!steady) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            burst_left = $urandom_range(0, 15);
         end
      end
   endtask

   // Stops sending and waits until every outstanding query has answered.
   task automatic drain_matches();
      start <= 1'b0;
      while (pending_matches.size() != 0 || busy) @(posedge clock);
   endtask

   // Rewrites the entry count with the block idle, then reads it back. The
   // upper data bits carry random junk that the register must drop.
   task automatic set_entry_count(input logic [6:0] count);
      logic [CSR_DATA_W-1:0] word;
      logic [CSR_DATA_W-1:0] seen;
      word      = $urandom();
      word[6:0] = count;
      drain_matches();
      repeat (4) @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ENTRY_COUNT_ADDR;
      pwdata  <= word;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      active_entries = count;
      count_settings++;
      // Back-to-back read: a fresh setup phase with psel still high.
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      seen = prdata;
      if (seen !== {{(CSR_DATA_W - 7){1'b0}}, count}) begin
         errors++;
         $display("%0t: entry_count readback expected %h got %h", $time,
                  {{(CSR_DATA_W - 7){1'b0}}, count}, seen);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic check_field(input string label, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s expected %h got %h", $time, label, want, got);
      end
   endtask

   // Response checker. The receiver cannot stall, so every strobe is taken
   // and matched against the oldest expected response.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_matches.size() == 0) begin
            errors++;
            $display("%0t: response with no query outstanding", $time);
         end else begin
            oldest_match = pending_matches.pop_front();
            check_field("match_valid", 16'(oldest_match.valid), 16'(rsp_match_valid));
            check_field("match_u0", oldest_match.coords[63:48], rsp_match_u0);
            check_field("match_v0", oldest_match.coords[47:32], rsp_match_v0);
            check_field("match_u1", oldest_match.coords[31:16], rsp_match_u1);
            check_field("match_v1", oldest_match.coords[15:0],  rsp_match_v1);
            responses_seen++;
         end
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   logic [6:0] count_plan [8] = '{7'd64, 7'd127, 7'd65, 7'd0, 7'd1, 7'd2, 7'd100, 7'd63};

   initial begin
      script_row_type row;
      logic [6:0]     count;
      logic [23:0]    rgb;
      errors          = 0;
      cycle_count     = 0;
      loads_sent      = 0;
      queries_sent    = 0;
      responses_seen  = 0;
      count_settings  = 0;
      burst_left      = 0;
      steady          = 1'b0;
      active_entries  = 0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         palette_rgb[i]    = '0;
         palette_coords[i] = '0;
         palette_placed[i] = 1'b0;
      end

      reset           <= 1'b1;
      start           <= 1'b0;
      req_type        <= REQ_LOAD;
      req_entry_index <= '0;
      req_color_r     <= '0;
      req_color_g     <= '0;
      req_color_b     <= '0;
      req_ref_u0      <= '0;
      req_ref_v0      <= '0;
      req_ref_u1      <= '0;
      req_ref_v1      <= '0;
      req_ref_valid   <= 1'b0;
      psel            <= 1'b0;
      penable         <= 1'b0;
      pwrite          <= 1'b0;
      paddr           <= '0;
      pwdata          <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed script. Entry count is zero out of reset, so the first
      // queries must see an empty table.
      foreach (directed_script[i]) begin
         row = directed_script[i];
         if (row.set_count) begin
            set_entry_count(row.count);
         end
         issue(row.kind, row.index, row.rgb, row.coords, row.placed, row.fixed,
               match_type'({row.exp_valid, row.exp_coords}));
         pace();
      end

      // Fill the whole table so that any entry count, saturated ones too,
      // scans only written entries from here on.
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         issue(REQ_LOAD, 6'(i), random_color(), random_coords(), 1'($urandom()), 1'b0, '0);
         pace();
      end

      // Random phases, each under its own entry count. The first few walk
      // the extremes: full, saturated, just above the depth, empty, one.
      // Queries dominate; loads keep rewriting entries, often with colors
      // copied from other entries so that ties keep showing up.
      for (int p = 0; p < PHASES; p++) begin
         if (p < 8) begin
            count = count_plan[p];
         end else if ($urandom_range(0, 3) == 0) begin
            count = ($urandom_range(0, 1) == 0) ? 7'd64 : 7'd127;
         end else begin
            count = 7'($urandom_range(0, 127));
         end
         set_entry_count(count);
         steady = (p % 5 == 2);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (p == 9 && k == PHASE_ITEMS / 2) begin
               // Let the pipeline run dry in the middle of a phase.
               drain_matches();
            end
            rgb = random_color();
            if ($urandom_range(0, 3) != 0) begin
               issue(REQ_QUERY, 6'($urandom()), rgb, random_coords(), 1'($urandom()),
                     1'b0, '0);
            end else begin
               issue(REQ_LOAD, 6'($urandom()), rgb, random_coords(), 1'($urandom()),
                     1'b0, '0);
            end
            pace();
         end
      end

      drain_matches();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d loads and %0d queries over %0d entry count settings.",
               loads_sent, queries_sent, count_settings);
      $display("Responses checked: %0d, mismatches: %0d.", responses_seen, errors);
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
